FILE: rtl/thick_line_span_generator_macros.svh
// Assertion macros used by the thick line span generator checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef THICK_LINE_SPAN_GENERATOR_MACROS_SVH
`define THICK_LINE_SPAN_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLSG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TLSG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tlsg_pkg.sv
// Shared types and constants of the thick line span generator.
// No dependencies; used by the span core, the top level and the checker.
`default_nettype none

package tlsg_pkg;

  localparam int COORD_BITS_DEF  = 16;
  localparam int RADIUS_BITS_DEF = 8;
  localparam int COLOR_BITS      = 16;

  // Row limit of the brush is r * 707 / 1000 + 1. The quotient is taken as a
  // multiply by a rounded-up reciprocal; the error stays below 1/1000 for
  // every radius of up to eight bits, so the floor is exact.
  localparam int unsigned ROW_NUM   = 707;
  localparam int unsigned ROW_DEN   = 1000;
  localparam int          ROW_SHIFT = 20;
  localparam int unsigned ROW_SCALE = (ROW_NUM * (2 ** ROW_SHIFT) + ROW_DEN - 1) / ROW_DEN;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd3
  } step_e;

  // Slot order within one brush stamp.
  typedef enum logic [2:0] {
    PH_CENTER      = 3'd0,
    PH_ROW_START   = 3'd1,
    PH_OUTER_ABOVE = 3'd2,
    PH_INNER_BELOW = 3'd3,
    PH_INNER_ABOVE = 3'd4
  } phase_e;

  typedef struct packed {
    logic fire;
    op_e  op;
  } issue_t;

endpackage

`default_nettype wire

FILE: rtl/thick_line_span_generator.sv
// An accepted item is held in the input register; its result is then loaded
// into the result register, which presents it.
// Throughput: one item per cycle unless the result register stalls; the input
// register and the result register each hold one item, and a stalled result
// register holds back the input. Reset (asynchronous, active low) empties both
// registers and leaves the generator idle with no line loaded.
`default_nettype none

module thick_line_span_generator #(
  parameter int COORD_BITS  = tlsg_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = tlsg_pkg::RADIUS_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            operation_i,
  input  logic [COORD_BITS-1:0]           x_start_i,
  input  logic [COORD_BITS-1:0]           y_start_i,
  input  logic [COORD_BITS-1:0]           x_end_i,
  input  logic [COORD_BITS-1:0]           y_end_i,
  input  logic [RADIUS_BITS-1:0]          brush_radius_i,
  input  logic [tlsg_pkg::COLOR_BITS-1:0] pixel_color_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            span_valid_o,
  output logic [COORD_BITS-1:0]           span_x_o,
  output logic [COORD_BITS-1:0]           span_y_o,
  output logic [RADIUS_BITS:0]            span_length_o,
  output logic [tlsg_pkg::COLOR_BITS-1:0] span_color_o,
  output logic                            accepted_o,
  output logic                            last_o
);

  localparam int ResBits = 2 * COORD_BITS + RADIUS_BITS + tlsg_pkg::COLOR_BITS + 4;

  logic                            in_valid_q, in_valid_d;
  tlsg_pkg::op_e                   op_q;
  logic [COORD_BITS-1:0]           x_start_q, y_start_q, x_end_q, y_end_q;
  logic [RADIUS_BITS-1:0]          radius_q;
  logic [tlsg_pkg::COLOR_BITS-1:0] color_q;
  logic                            capture;
  logic                            load_ready;
  tlsg_pkg::issue_t                issue;

  logic                            res_span_valid, res_accepted, res_last;
  logic [COORD_BITS-1:0]           res_x, res_y;
  logic [RADIUS_BITS:0]            res_length;
  logic [tlsg_pkg::COLOR_BITS-1:0] res_color;
  logic [ResBits-1:0]              res_data, out_data;

  assign in_ready_o = !in_valid_q || load_ready;
  assign capture    = in_valid_i && in_ready_o;
  assign in_valid_d = in_ready_o ? in_valid_i : in_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture) begin
      op_q      <= tlsg_pkg::op_e'(operation_i);
      x_start_q <= x_start_i;
      y_start_q <= y_start_i;
      x_end_q   <= x_end_i;
      y_end_q   <= y_end_i;
      radius_q  <= brush_radius_i;
      color_q   <= pixel_color_i;
    end
  end

  assign issue.fire = in_valid_q && load_ready;
  assign issue.op   = op_q;

  tlsg_span_core #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS)
  ) u_span_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .issue_i       (issue),
    .x_start_i     (x_start_q),
    .y_start_i     (y_start_q),
    .x_end_i       (x_end_q),
    .y_end_i       (y_end_q),
    .brush_radius_i(radius_q),
    .pixel_color_i (color_q),
    .span_valid_o  (res_span_valid),
    .span_x_o      (res_x),
    .span_y_o      (res_y),
    .span_length_o (res_length),
    .span_color_o  (res_color),
    .accepted_o    (res_accepted),
    .last_o        (res_last)
  );

  assign res_data = {res_span_valid, res_x, res_y, res_length, res_color,
                     res_accepted, res_last};

  tlsg_out_reg #(
    .WIDTH(ResBits)
  ) u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_valid_i(in_valid_q),
    .load_ready_o(load_ready),
    .load_data_i (res_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign {span_valid_o, span_x_o, span_y_o, span_length_o, span_color_o,
          accepted_o, last_o} = out_data;

endmodule

`default_nettype wire

FILE: rtl/tlsg_span_core.sv
// Line stepping and brush span state of the thick line span generator.
// Depends on tlsg_pkg; produces one result per issued item combinationally.
`default_nettype none

module tlsg_span_core #(
  parameter int COORD_BITS  = tlsg_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = tlsg_pkg::RADIUS_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tlsg_pkg::issue_t                issue_i,
  input  logic [COORD_BITS-1:0]           x_start_i,
  input  logic [COORD_BITS-1:0]           y_start_i,
  input  logic [COORD_BITS-1:0]           x_end_i,
  input  logic [COORD_BITS-1:0]           y_end_i,
  input  logic [RADIUS_BITS-1:0]          brush_radius_i,
  input  logic [tlsg_pkg::COLOR_BITS-1:0] pixel_color_i,
  output logic                            span_valid_o,
  output logic [COORD_BITS-1:0]           span_x_o,
  output logic [COORD_BITS-1:0]           span_y_o,
  output logic [RADIUS_BITS:0]            span_length_o,
  output logic [tlsg_pkg::COLOR_BITS-1:0] span_color_o,
  output logic                            accepted_o,
  output logic                            last_o
);

  localparam int CB       = COORD_BITS;
  localparam int RB       = RADIUS_BITS;
  localparam int RowShift = tlsg_pkg::ROW_SHIFT;
  localparam int ProdBits = RB + RowShift;
  localparam logic [RowShift-1:0] RowScale = RowShift'(tlsg_pkg::ROW_SCALE);

  // Line state
  logic                            active_q, active_d;
  logic [CB-1:0]                   point_x_q, point_x_d, point_y_q, point_y_d;
  tlsg_pkg::step_e                 step_x_q, step_x_d, step_y_q, step_y_d;
  logic [CB-1:0]                   abs_dx_q, abs_dx_d, abs_dy_q, abs_dy_d;
  logic [CB-1:0]                   major_q, major_d;
  logic [CB-1:0]                   err_x_q, err_x_d, err_y_q, err_y_d;
  logic [CB:0]                     point_count_q, point_count_d;
  logic [RB-1:0]                   row_index_q, row_index_d;
  logic [RB-1:0]                   circle_x_q, circle_x_d;
  logic [RB-1:0]                   row_limit_q, row_limit_d;
  logic [2*RB-1:0]                 square_limit_q, square_limit_d;
  tlsg_pkg::phase_e                phase_q, phase_d;
  logic [RB-1:0]                   radius_q, radius_d;
  logic [tlsg_pkg::COLOR_BITS-1:0] color_q, color_d;

  // Start decode
  logic                  start_ok;
  tlsg_pkg::step_e       new_step_x, new_step_y;
  logic [CB-1:0]         new_abs_dx, new_abs_dy, new_major;
  logic [ProdBits-1:0]   row_prod;
  logic [RB-1:0]         new_row_limit;
  logic [2*RB-1:0]       new_square_limit;

  // Slot decode
  logic [2*RB-1:0]       row_sq, col_sq;
  logic [2*RB:0]         dist_sq;
  logic                  cut, outer, point_done, line_done;
  logic [RB-1:0]         cx_dec, cx_row, i_m1;
  logic [CB:0]           err_x_sum, err_y_sum;
  logic [CB:0]           count_dec;

  // Result assembly
  logic                  show_span, y_neg, res_last, res_acc;
  logic [RB-1:0]         x_off, y_off, len_half;

  assign start_ok = (x_start_i >= CB'(brush_radius_i)) && (x_end_i >= CB'(brush_radius_i)) &&
                    (y_start_i >= CB'(brush_radius_i)) && (y_end_i >= CB'(brush_radius_i));

  always_comb begin
    if (x_end_i > x_start_i) begin
      new_step_x = tlsg_pkg::STEP_UP;
      new_abs_dx = x_end_i - x_start_i;
    end else if (x_end_i == x_start_i) begin
      new_step_x = tlsg_pkg::STEP_NONE;
      new_abs_dx = '0;
    end else begin
      new_step_x = tlsg_pkg::STEP_DOWN;
      new_abs_dx = x_start_i - x_end_i;
    end
    if (y_end_i > y_start_i) begin
      new_step_y = tlsg_pkg::STEP_UP;
      new_abs_dy = y_end_i - y_start_i;
    end else if (y_end_i == y_start_i) begin
      new_step_y = tlsg_pkg::STEP_NONE;
      new_abs_dy = '0;
    end else begin
      new_step_y = tlsg_pkg::STEP_DOWN;
      new_abs_dy = y_start_i - y_end_i;
    end
  end

  assign new_major = (new_abs_dx > new_abs_dy) ? new_abs_dx : new_abs_dy;

  assign row_prod      = ProdBits'(brush_radius_i) * ProdBits'(RowScale);
  assign new_row_limit = row_prod[RowShift +: RB] + RB'(1);
  assign new_square_limit = (2*RB)'(brush_radius_i) * (2*RB)'(brush_radius_i)
                          + (2*RB)'(brush_radius_i >> 1);

  // A row is cut once it leaves the circle; wide brushes then emit the
  // outer pair before the inner pair of that row.
  assign row_sq     = (2*RB)'(row_index_q) * (2*RB)'(row_index_q);
  assign col_sq     = (2*RB)'(circle_x_q) * (2*RB)'(circle_x_q);
  assign dist_sq    = {1'b0, row_sq} + {1'b0, col_sq};
  assign cut        = dist_sq > {1'b0, square_limit_q};
  assign outer      = cut && (circle_x_q > row_limit_q);
  assign cx_dec     = (circle_x_q != '0) ? circle_x_q - RB'(1) : circle_x_q;
  assign cx_row     = cut ? cx_dec : circle_x_q;
  assign i_m1       = row_index_q - RB'(1);
  assign point_done = row_index_q >= row_limit_q;
  assign line_done  = point_done && (point_count_q <= (CB+1)'(1));

  assign err_x_sum = {1'b0, err_x_q} + {1'b0, abs_dx_q};
  assign err_y_sum = {1'b0, err_y_q} + {1'b0, abs_dy_q};
  assign count_dec = (point_count_q != '0) ? point_count_q - (CB+1)'(1) : point_count_q;

  always_comb begin
    active_d       = active_q;
    point_x_d      = point_x_q;
    point_y_d      = point_y_q;
    step_x_d       = step_x_q;
    step_y_d       = step_y_q;
    abs_dx_d       = abs_dx_q;
    abs_dy_d       = abs_dy_q;
    major_d        = major_q;
    err_x_d        = err_x_q;
    err_y_d        = err_y_q;
    point_count_d  = point_count_q;
    row_index_d    = row_index_q;
    circle_x_d     = circle_x_q;
    row_limit_d    = row_limit_q;
    square_limit_d = square_limit_q;
    phase_d        = phase_q;
    radius_d       = radius_q;
    color_d        = color_q;
    show_span      = 1'b0;
    y_neg          = 1'b0;
    res_last       = 1'b0;
    res_acc        = 1'b0;
    x_off          = '0;
    y_off          = '0;
    len_half       = '0;

    if (issue_i.fire) begin
      if (issue_i.op == tlsg_pkg::OP_START) begin
        if (!start_ok) begin
          active_d = 1'b0;
          res_last = 1'b1;
        end else begin
          active_d       = 1'b1;
          res_acc        = 1'b1;
          radius_d       = brush_radius_i;
          color_d        = pixel_color_i;
          point_x_d      = x_start_i;
          point_y_d      = y_start_i;
          step_x_d       = new_step_x;
          step_y_d       = new_step_y;
          abs_dx_d       = new_abs_dx;
          abs_dy_d       = new_abs_dy;
          major_d        = new_major;
          err_x_d        = '0;
          err_y_d        = '0;
          point_count_d  = (CB+1)'(new_major) + (CB+1)'(2);
          row_limit_d    = new_row_limit;
          square_limit_d = new_square_limit;
          circle_x_d     = brush_radius_i;
          row_index_d    = '0;
          phase_d        = tlsg_pkg::PH_CENTER;
        end
      end else if (!active_q) begin
        res_last = 1'b1;
      end else begin
        show_span = 1'b1;
        unique case (phase_q)
          tlsg_pkg::PH_CENTER: begin
            x_off       = radius_q;
            len_half    = radius_q;
            row_index_d = RB'(1);
            phase_d     = tlsg_pkg::PH_ROW_START;
          end
          tlsg_pkg::PH_ROW_START: begin
            if (outer) begin
              x_off    = i_m1;
              y_off    = circle_x_q;
              len_half = i_m1;
              phase_d  = tlsg_pkg::PH_OUTER_ABOVE;
            end else begin
              circle_x_d = cx_row;
              x_off      = cx_row;
              y_off      = row_index_q;
              len_half   = cx_row;
              phase_d    = tlsg_pkg::PH_INNER_ABOVE;
            end
          end
          tlsg_pkg::PH_OUTER_ABOVE: begin
            x_off      = i_m1;
            y_off      = circle_x_q;
            y_neg      = 1'b1;
            len_half   = i_m1;
            circle_x_d = cx_dec;
            phase_d    = tlsg_pkg::PH_INNER_BELOW;
          end
          tlsg_pkg::PH_INNER_BELOW: begin
            x_off    = circle_x_q;
            y_off    = row_index_q;
            len_half = circle_x_q;
            phase_d  = tlsg_pkg::PH_INNER_ABOVE;
          end
          default: begin
            x_off    = circle_x_q;
            y_off    = row_index_q;
            y_neg    = 1'b1;
            len_half = circle_x_q;
            res_last = line_done;
            if (point_done) begin
              // Step the line to its next point and restart the brush.
              if (err_x_sum > {1'b0, major_q}) begin
                err_x_d = CB'(err_x_sum - {1'b0, major_q});
                unique case (step_x_q)
                  tlsg_pkg::STEP_UP:   point_x_d = point_x_q + CB'(1);
                  tlsg_pkg::STEP_DOWN: point_x_d = point_x_q - CB'(1);
                  default:             point_x_d = point_x_q;
                endcase
              end else begin
                err_x_d = err_x_sum[CB-1:0];
              end
              if (err_y_sum > {1'b0, major_q}) begin
                err_y_d = CB'(err_y_sum - {1'b0, major_q});
                unique case (step_y_q)
                  tlsg_pkg::STEP_UP:   point_y_d = point_y_q + CB'(1);
                  tlsg_pkg::STEP_DOWN: point_y_d = point_y_q - CB'(1);
                  default:             point_y_d = point_y_q;
                endcase
              end else begin
                err_y_d = err_y_sum[CB-1:0];
              end
              point_count_d = count_dec;
              if (count_dec == '0) begin
                active_d = 1'b0;
              end
              circle_x_d  = radius_q;
              row_index_d = '0;
              phase_d     = tlsg_pkg::PH_CENTER;
            end else begin
              row_index_d = row_index_q + RB'(1);
              phase_d     = tlsg_pkg::PH_ROW_START;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    span_length_o = show_span ? {len_half, 1'b0} : '0;
    span_valid_o  = show_span && (len_half != '0);
    span_x_o      = show_span ? point_x_q - CB'(x_off) : '0;
    if (!show_span) begin
      span_y_o = '0;
    end else if (y_neg) begin
      span_y_o = point_y_q - CB'(y_off);
    end else begin
      span_y_o = point_y_q + CB'(y_off);
    end
    span_color_o = show_span ? color_q : '0;
    accepted_o   = res_acc;
    last_o       = res_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q      <= 1'b0;
      phase_q       <= tlsg_pkg::PH_CENTER;
      point_count_q <= '0;
      row_index_q   <= '0;
      circle_x_q    <= '0;
    end else begin
      active_q      <= active_d;
      phase_q       <= phase_d;
      point_count_q <= point_count_d;
      row_index_q   <= row_index_d;
      circle_x_q    <= circle_x_d;
    end
  end

  always_ff @(posedge clk_i) begin
    point_x_q      <= point_x_d;
    point_y_q      <= point_y_d;
    step_x_q       <= step_x_d;
    step_y_q       <= step_y_d;
    abs_dx_q       <= abs_dx_d;
    abs_dy_q       <= abs_dy_d;
    major_q        <= major_d;
    err_x_q        <= err_x_d;
    err_y_q        <= err_y_d;
    row_limit_q    <= row_limit_d;
    square_limit_q <= square_limit_d;
    radius_q       <= radius_d;
    color_q        <= color_d;
  end

endmodule

`default_nettype wire

FILE: rtl/tlsg_out_reg.sv
// Result register with valid/ready handshake for the span generator.
// No package dependencies; a new result loads whenever the register is free or drains.
`default_nettype none

module tlsg_out_reg #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_valid_i,
  output logic             load_ready_o,
  input  logic [WIDTH-1:0] load_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);

  logic             valid_q, valid_d;
  logic [WIDTH-1:0] data_q;
  logic             load;

  assign load_ready_o = !valid_q || out_ready_i;
  assign load         = load_valid_i && load_ready_o;

  always_comb begin
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= load_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

FILE: rtl/tlsg_checker.sv
// Port-level checks of the thick line span generator, bound to the top level.
// Depends on tlsg_pkg and thick_line_span_generator_macros.svh.
`default_nettype none
`include "thick_line_span_generator_macros.svh"

module tlsg_checker #(
  parameter int COORD_BITS = tlsg_pkg::COORD_BITS_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic                  span_valid_i,
  input logic [COORD_BITS-1:0] span_x_i,
  input logic                  accepted_i,
  input logic                  last_i
);

  // A stalled result keeps its contents.
  `TLSG_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(span_x_i) && $stable(last_i), "stalled result changed")

  // A fresh result must trace back to an item taken by the input handshake.
  `TLSG_ASSERT_IMP(a_no_phantom, clk_i, rst_ni, $rose(out_valid_i), $past(in_valid_i && in_ready_i, 2), "result without an item")

  // With one item held and the result stalled, the input must back off.
  `TLSG_ASSERT_IMP(a_backpressure, clk_i, rst_ni, (in_valid_i && in_ready_i) ##1 (out_valid_i && !out_ready_i), !in_ready_i, "input taken while full")

  // The result of an accepted start carries no span and does not end a line.
  `TLSG_ASSERT_IMP(a_start_result, clk_i, rst_ni, out_valid_i && accepted_i, !span_valid_i && !last_i, "bad start result")

endmodule

bind thick_line_span_generator tlsg_checker #(
  .COORD_BITS(COORD_BITS)
) u_tlsg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .span_valid_i(span_valid_o),
  .span_x_i    (span_x_o),
  .accepted_i  (accepted_o),
  .last_i      (last_o)
);

`default_nettype wire
